FILE: rtl/core/cpc_pkg.sv
// Package for the complex-to-polar converter: widths, payload structs and the
// CORDIC arc-tangent table. Used by every module in rtl/core; depends on nothing.
package cpc_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int ATAN_LEN      = 24;
    localparam int STAGES_USED   = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;

    // Fraction guard bits added below the sample LSB inside the CORDIC.
    localparam int GUARD   = 39 - SAMPLE_BITS;
    // Sample plus guard bits plus room for the CORDIC gain and the pre-rotation.
    localparam int DATA_W  = SAMPLE_BITS + GUARD + 3;
    // Angle accumulator: 2^32 units per turn plus headroom for the stage sum.
    localparam int ANGLE_W = 34;

    localparam int MAG_W    = 16;
    localparam int PHASE_W  = 16;
    localparam int INTEN_W  = 32;

    localparam int GAIN_W   = 24;
    localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;

    // The non-negative x is split in two halves for the gain multiply.
    localparam int XU_W  = DATA_W - 1;
    localparam int XLO_W = (XU_W + 1) / 2;
    localparam int XHI_W = XU_W - XLO_W;
    localparam int PROD_W = XU_W + GAIN_W + 1;

    // Accept edge to output strobe: pre-rotation, CORDIC stages, two gain stages.
    localparam int LATENCY = STAGES_USED + 3;

    localparam logic [31:0] ATAN_TABLE [0:ATAN_LEN-1] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    localparam logic signed [ANGLE_W-1:0] QUARTER_TURN = ANGLE_W'(32'h40000000);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_real;
        logic signed [SAMPLE_BITS-1:0] sample_imag;
    } t_sample;

    typedef struct packed {
        logic [MAG_W-1:0]          magnitude_out;
        logic signed [PHASE_W-1:0] phase_out;
        logic [INTEN_W-1:0]        intensity_out;
    } t_result;

    // Axis and sign information of the original sample, carried alongside the data.
    typedef struct packed {
        logic re_zero;
        logic im_zero;
        logic re_neg;
        logic im_pos;
    } t_flags;

endpackage

FILE: rtl/core/complex_polar_convert.sv
// Complex sample to polar form: magnitude, phase and intensity.
// Top level; instantiates cpc_cordic, cpc_gain and cpc_power, uses cpc_pkg.
//
// A word is accepted at a rising edge where start is high and busy is low.
// busy is always low, so a new sample may be presented on every cycle.
// Each accepted word produces exactly one result word: o_valid is high for one
// cycle with o_result holding magnitude, phase and intensity together.
// Between the accept edge and the o_valid cycle lie one pre-rotation stage,
// sixteen CORDIC stages with one add/subtract per stage, and two stages for
// the split gain multiply and rounding.
// Throughput is one word per cycle; the unrolled CORDIC stages set the depth.
// The receiver has no way to stall, so results are never held back.
// Reset clears the valid bits of the pipeline; words in flight are dropped and
// no result appears until a new word is accepted. No state is kept between
// words.
module complex_polar_convert (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cpc_pkg::t_sample     i_sample,
    output logic                 o_valid,
    output cpc_pkg::t_result     o_result
);

    logic                                  w_accept;
    logic                                  w_cordic_valid;
    logic signed [cpc_pkg::DATA_W-1:0]     w_x;
    logic signed [cpc_pkg::ANGLE_W-1:0]    w_z;
    cpc_pkg::t_flags                       w_flags;
    logic [cpc_pkg::MAG_W-1:0]             w_magnitude;
    logic signed [cpc_pkg::PHASE_W-1:0]    w_phase;
    logic [cpc_pkg::INTEN_W-1:0]           w_intensity;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    cpc_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_sample(i_sample),
        .o_valid (w_cordic_valid),
        .o_x     (w_x),
        .o_z     (w_z),
        .o_flags (w_flags)
    );

    cpc_gain u_gain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (w_cordic_valid),
        .i_x        (w_x),
        .i_z        (w_z),
        .i_flags    (w_flags),
        .o_valid    (o_valid),
        .o_magnitude(w_magnitude),
        .o_phase    (w_phase)
    );

    cpc_power u_power (
        .i_clk      (i_clk),
        .i_sample   (i_sample),
        .o_intensity(w_intensity)
    );

    assign o_result.magnitude_out = w_magnitude;
    assign o_result.phase_out     = w_phase;
    assign o_result.intensity_out = w_intensity;

endmodule

FILE: rtl/core/cpc_cordic.sv
// Pre-rotation into the right half plane followed by the unrolled CORDIC
// vectoring stages, one register stage per iteration. Depends on cpc_pkg.
module cpc_cordic (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  cpc_pkg::t_sample                      i_sample,
    output logic                                  o_valid,
    output logic signed [cpc_pkg::DATA_W-1:0]     o_x,
    output logic signed [cpc_pkg::ANGLE_W-1:0]    o_z,
    output cpc_pkg::t_flags                       o_flags
);

    localparam int N = cpc_pkg::STAGES_USED;

    logic signed [cpc_pkg::DATA_W-1:0]  r_x [0:N];
    logic signed [cpc_pkg::DATA_W-1:0]  r_y [0:N];
    logic signed [cpc_pkg::ANGLE_W-1:0] r_z [0:N];
    cpc_pkg::t_flags                    r_flags [0:N];
    logic [N:0]                         r_valid;

    logic signed [cpc_pkg::DATA_W-1:0]  n_x0;
    logic signed [cpc_pkg::DATA_W-1:0]  n_y0;
    logic signed [cpc_pkg::ANGLE_W-1:0] n_z0;
    logic signed [cpc_pkg::DATA_W-1:0]  w_re;
    logic signed [cpc_pkg::DATA_W-1:0]  w_im;
    cpc_pkg::t_flags                    n_flags0;

    always_comb begin
        w_re = cpc_pkg::DATA_W'(i_sample.sample_real) <<< cpc_pkg::GUARD;
        w_im = cpc_pkg::DATA_W'(i_sample.sample_imag) <<< cpc_pkg::GUARD;
        n_x0 = w_re;
        n_y0 = w_im;
        n_z0 = '0;
        // Left half plane: turn by a quarter so that stage 0 starts with x >= 0.
        if (w_re < 0) begin
            if (w_im >= 0) begin
                n_x0 = w_im;
                n_y0 = -w_re;
                n_z0 = cpc_pkg::QUARTER_TURN;
            end else begin
                n_x0 = -w_im;
                n_y0 = w_re;
                n_z0 = -cpc_pkg::QUARTER_TURN;
            end
        end
        n_flags0.re_zero = (i_sample.sample_real == '0);
        n_flags0.im_zero = (i_sample.sample_imag == '0);
        n_flags0.re_neg  = i_sample.sample_real[cpc_pkg::SAMPLE_BITS-1];
        n_flags0.im_pos  = !i_sample.sample_imag[cpc_pkg::SAMPLE_BITS-1]
                           && (i_sample.sample_imag != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else begin
            r_valid[0] <= i_valid;
        end
        r_x[0]     <= n_x0;
        r_y[0]     <= n_y0;
        r_z[0]     <= n_z0;
        r_flags[0] <= n_flags0;
    end

    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [cpc_pkg::ANGLE_W-1:0] ATAN_K =
            cpc_pkg::ANGLE_W'(cpc_pkg::ATAN_TABLE[k]);

        logic signed [cpc_pkg::DATA_W-1:0]  n_x;
        logic signed [cpc_pkg::DATA_W-1:0]  n_y;
        logic signed [cpc_pkg::ANGLE_W-1:0] n_z;
        logic signed [cpc_pkg::DATA_W-1:0]  w_dx;
        logic signed [cpc_pkg::DATA_W-1:0]  w_dy;

        always_comb begin
            w_dx = r_y[k] >>> k;
            w_dy = r_x[k] >>> k;
            if (r_y[k] >= 0) begin
                n_x = r_x[k] + w_dx;
                n_y = r_y[k] - w_dy;
                n_z = r_z[k] + ATAN_K;
            end else begin
                n_x = r_x[k] - w_dx;
                n_y = r_y[k] + w_dy;
                n_z = r_z[k] - ATAN_K;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k+1] <= 1'b0;
            end else begin
                r_valid[k+1] <= r_valid[k];
            end
            r_x[k+1]     <= n_x;
            r_y[k+1]     <= n_y;
            r_z[k+1]     <= n_z;
            r_flags[k+1] <= r_flags[k];
        end
    end

    assign o_valid = r_valid[N];
    assign o_x     = r_x[N];
    assign o_z     = r_z[N];
    assign o_flags = r_flags[N];

endmodule

FILE: rtl/core/cpc_gain.sv
// Gain compensation and rounding of the CORDIC magnitude, phase rounding and
// the exact-axis overrides, over two register stages. Depends on cpc_pkg.
module cpc_gain (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    input  logic signed [cpc_pkg::DATA_W-1:0]     i_x,
    input  logic signed [cpc_pkg::ANGLE_W-1:0]    i_z,
    input  cpc_pkg::t_flags                       i_flags,
    output logic                                  o_valid,
    output logic [cpc_pkg::MAG_W-1:0]             o_magnitude,
    output logic signed [cpc_pkg::PHASE_W-1:0]    o_phase
);

    localparam int LO_PROD_W = cpc_pkg::XLO_W + cpc_pkg::GAIN_W;
    localparam int HI_PROD_W = cpc_pkg::XHI_W + cpc_pkg::GAIN_W;
    localparam int RND_SHIFT = 24 + cpc_pkg::GUARD;

    logic [cpc_pkg::XU_W-1:0]          w_xu;
    logic [cpc_pkg::ANGLE_W-1:0]       w_zr;

    logic                              r_valid_a;
    logic [LO_PROD_W-1:0]              r_prod_lo;
    logic [HI_PROD_W-1:0]              r_prod_hi;
    logic [cpc_pkg::PHASE_W-1:0]       r_phase_a;
    cpc_pkg::t_flags                   r_flags_a;

    logic [cpc_pkg::PROD_W-1:0]        w_sum;
    logic [cpc_pkg::PROD_W-1:0]        w_mag_full;
    logic [cpc_pkg::MAG_W-1:0]         n_magnitude;
    logic [cpc_pkg::PHASE_W-1:0]       n_phase;

    logic                              r_valid;
    logic [cpc_pkg::MAG_W-1:0]         r_magnitude;
    logic [cpc_pkg::PHASE_W-1:0]       r_phase;

    // A negative final x counts as zero magnitude.
    assign w_xu = i_x[cpc_pkg::DATA_W-1] ? '0 : i_x[cpc_pkg::XU_W-1:0];
    assign w_zr = i_z + cpc_pkg::ANGLE_W'(32'h8000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
        end else begin
            r_valid_a <= i_valid;
        end
        r_prod_lo <= LO_PROD_W'(w_xu[cpc_pkg::XLO_W-1:0]) * LO_PROD_W'(cpc_pkg::GAIN_Q24);
        r_prod_hi <= HI_PROD_W'(w_xu[cpc_pkg::XU_W-1:cpc_pkg::XLO_W])
                     * HI_PROD_W'(cpc_pkg::GAIN_Q24);
        r_phase_a <= w_zr[31:16];
        r_flags_a <= i_flags;
    end

    always_comb begin
        w_sum = (cpc_pkg::PROD_W'(r_prod_hi) << cpc_pkg::XLO_W)
                + cpc_pkg::PROD_W'(r_prod_lo)
                + (cpc_pkg::PROD_W'(1) << (RND_SHIFT - 1));
        w_mag_full = w_sum >> RND_SHIFT;
        if (w_mag_full > cpc_pkg::PROD_W'({cpc_pkg::MAG_W{1'b1}})) begin
            n_magnitude = '1;
        end else begin
            n_magnitude = w_mag_full[cpc_pkg::MAG_W-1:0];
        end

        // Samples on an axis get the exact angle rather than the CORDIC estimate.
        if (r_flags_a.im_zero) begin
            n_phase = r_flags_a.re_neg ? 16'h8000 : 16'h0000;
        end else if (r_flags_a.re_zero) begin
            n_phase = r_flags_a.im_pos ? 16'h4000 : 16'hC000;
        end else begin
            n_phase = r_phase_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_valid_a;
        end
        r_magnitude <= n_magnitude;
        r_phase     <= n_phase;
    end

    assign o_valid     = r_valid;
    assign o_magnitude = r_magnitude;
    assign o_phase     = r_phase;

endmodule

FILE: rtl/core/cpc_power.sv
// Exact sum of squares of the sample, delayed to line up with the CORDIC
// results at the output. Depends on cpc_pkg.
module cpc_power (
    input  logic                           i_clk,
    input  cpc_pkg::t_sample               i_sample,
    output logic [cpc_pkg::INTEN_W-1:0]    o_intensity
);

    localparam int SQ_W  = 2 * cpc_pkg::SAMPLE_BITS;
    localparam int DEPTH = cpc_pkg::LATENCY - 2;

    logic signed [SQ_W-1:0]          r_sq_re;
    logic signed [SQ_W-1:0]          r_sq_im;
    logic [cpc_pkg::INTEN_W-1:0]     r_line [0:DEPTH];
    logic [SQ_W:0]                   w_sum;

    always_ff @(posedge i_clk) begin
        r_sq_re <= SQ_W'(i_sample.sample_real) * SQ_W'(i_sample.sample_real);
        r_sq_im <= SQ_W'(i_sample.sample_imag) * SQ_W'(i_sample.sample_imag);
    end

    // Both squares are non-negative, so they add as unsigned values.
    assign w_sum = {1'b0, r_sq_re} + {1'b0, r_sq_im};

    always_ff @(posedge i_clk) begin
        r_line[0] <= cpc_pkg::INTEN_W'(w_sum);
    end

    for (genvar k = 0; k < DEPTH; k++) begin : g_delay
        always_ff @(posedge i_clk) begin
            r_line[k+1] <= r_line[k];
        end
    end

    assign o_intensity = r_line[DEPTH];

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for complex_polar_convert: directed table plus random words.
// Depends on cpc_pkg and the complex_polar_convert RTL only.
module tb_top;

    localparam logic [2:0] KNOWN_NONE = 3'b000;
    localparam logic [2:0] KNOWN_MAG  = 3'b100;
    localparam logic [2:0] KNOWN_PH   = 3'b010;
    localparam logic [2:0] KNOWN_INT  = 3'b001;
    localparam logic [2:0] KNOWN_ALL  = 3'b111;

    localparam int RANDOM_WORDS  = 1280;
    localparam int DIRECTED_ROWS = 22;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [2:0]         known;
        logic [15:0]        mag;
        logic signed [15:0] ph;
        logic [31:0]        inten;
    } t_row;

    // Fields marked known are typed in; the rest come from the polar predictor.
    localparam t_row DIRECTED [0:DIRECTED_ROWS-1] = '{
        '{16'sh0000, 16'sh0000, KNOWN_ALL, 16'd0, 16'sh0000, 32'd0},
        '{16'sh7FFF, 16'sh0000, KNOWN_PH | KNOWN_INT, 16'd0, 16'sh0000, 32'd1073676289},
        '{16'sh8000, 16'sh0000, KNOWN_PH | KNOWN_INT, 16'd0, 16'sh8000, 32'd1073741824},
        '{16'sh0001, 16'sh0000, KNOWN_PH | KNOWN_INT, 16'd0, 16'sh0000, 32'd1},
        '{16'shFFFF, 16'sh0000, KNOWN_PH | KNOWN_INT, 16'd0, 16'sh8000, 32'd1},
        '{16'sh0000, 16'sh7FFF, KNOWN_PH | KNOWN_INT, 16'd0, 16'sh4000, 32'd1073676289},
        '{16'sh0000, 16'sh8000, KNOWN_PH | KNOWN_INT, 16'd0, 16'shC000, 32'd1073741824},
        '{16'sh0000, 16'sh0001, KNOWN_PH | KNOWN_INT, 16'd0, 16'sh4000, 32'd1},
        '{16'sh0000, 16'shFFFF, KNOWN_PH | KNOWN_INT, 16'd0, 16'shC000, 32'd1},
        '{16'sh7FFF, 16'sh7FFF, KNOWN_INT, 16'd0, 16'sh0000, 32'd2147352578},
        '{16'sh8000, 16'sh8000, KNOWN_INT, 16'd0, 16'sh0000, 32'd2147483648},
        '{16'sh7FFF, 16'sh8000, KNOWN_INT, 16'd0, 16'sh0000, 32'd2147418113},
        '{16'sh8000, 16'sh7FFF, KNOWN_INT, 16'd0, 16'sh0000, 32'd2147418113},
        '{16'sh0001, 16'sh0001, KNOWN_INT, 16'd0, 16'sh0000, 32'd2},
        '{16'shFFFF, 16'shFFFF, KNOWN_INT, 16'd0, 16'sh0000, 32'd2},
        '{16'shFFFF, 16'sh0001, KNOWN_INT, 16'd0, 16'sh0000, 32'd2},
        '{16'sh0001, 16'shFFFF, KNOWN_INT, 16'd0, 16'sh0000, 32'd2},
        '{16'sh8000, 16'sh0001, KNOWN_INT, 16'd0, 16'sh0000, 32'd1073741825},
        '{16'sh8000, 16'shFFFF, KNOWN_INT, 16'd0, 16'sh0000, 32'd1073741825},
        '{16'shFFFF, 16'sh8000, KNOWN_INT, 16'd0, 16'sh0000, 32'd1073741825},
        '{16'sh3039, 16'shA460, KNOWN_NONE, 16'd0, 16'sh0000, 32'd0},
        '{16'shB1E0, 16'sh0005, KNOWN_NONE, 16'd0, 16'sh0000, 32'd0}
    };

    localparam logic signed [15:0] EDGE_VALS [0:5] = '{
        16'sh8000, 16'sh8001, 16'shFFFF, 16'sh0000, 16'sh0001, 16'sh7FFF
    };

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    cpc_pkg::t_sample   i_sample = '0;
    logic               o_valid;
    cpc_pkg::t_result   o_result;

    cpc_pkg::t_result   pending_polar[$];
    int                 words_sent = 0;
    int                 results_checked = 0;
    int                 mismatch_count = 0;

    complex_polar_convert uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_sample (i_sample),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Vectoring CORDIC on a 64-bit datapath, gain compensation and exact power.
    function automatic cpc_pkg::t_result polar_of(cpc_pkg::t_sample s);
        longint re, im, x, y, z, t, dx, dy;
        longint unsigned mag, ph, ar, ai;
        cpc_pkg::t_result r;
        re = longint'(s.sample_real);
        im = longint'(s.sample_imag);
        x = re * (64'sd1 <<< cpc_pkg::GUARD);
        y = im * (64'sd1 <<< cpc_pkg::GUARD);
        z = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;
                y = -t;
                z = 64'sh40000000;
            end else begin
                x = -y;
                y = t;
                z = -64'sh40000000;
            end
        end
        for (int i = 0; i < cpc_pkg::STAGES_USED; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx;
                y -= dy;
                z += longint'(cpc_pkg::ATAN_TABLE[i]);
            end else begin
                x -= dx;
                y += dy;
                z -= longint'(cpc_pkg::ATAN_TABLE[i]);
            end
        end
        if (x < 0)
            x = 0;
        mag = ($unsigned(x) * 64'(cpc_pkg::GAIN_Q24) + (64'd1 << (23 + cpc_pkg::GUARD)))
              >> (24 + cpc_pkg::GUARD);
        if (mag > 64'd65535)
            mag = 64'd65535;
        ph = (($unsigned(z) + 64'h8000) >> 16) & 64'hFFFF;
        if (im == 0)
            ph = (re < 0) ? 64'h8000 : 64'h0;
        else if (re == 0)
            ph = (im > 0) ? 64'h4000 : 64'hC000;
        ar = (re < 0) ? $unsigned(-re) : $unsigned(re);
        ai = (im < 0) ? $unsigned(-im) : $unsigned(im);
        r.magnitude_out = mag[15:0];
        r.phase_out     = ph[15:0];
        r.intensity_out = 32'(ar * ar + ai * ai);
        return r;
    endfunction

    function automatic cpc_pkg::t_sample random_word();
        cpc_pkg::t_sample w;
        w = $urandom;
        case ($urandom_range(9))
            4: begin
                w.sample_real = 16'(int'($urandom_range(128)) - 64);
                w.sample_imag = 16'(int'($urandom_range(128)) - 64);
            end
            5: begin
                if ($urandom_range(1))
                    w.sample_real = '0;
                else
                    w.sample_imag = '0;
            end
            6: begin
                w.sample_real = EDGE_VALS[$urandom_range(5)];
                w.sample_imag = EDGE_VALS[$urandom_range(5)];
            end
            7: begin
                // Hug the negative real axis, where the phase wraps around pi.
                w.sample_real = 16'(-int'($urandom_range(32768, 1)));
                w.sample_imag = 16'(int'($urandom_range(6)) - 3);
            end
            8: begin
                w.sample_real = w.sample_real >>> $urandom_range(15);
                w.sample_imag = w.sample_imag >>> $urandom_range(15);
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_word(input cpc_pkg::t_sample w, input cpc_pkg::t_result want);
        start    <= 1'b1;
        i_sample <= w;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_polar.insert(pending_polar.size(), want);
        words_sent++;
    endtask

    task automatic rest_after_word(input bit calm);
        int gap;
        int roll;
        roll = $urandom_range(99);
        if (calm || roll < 60)
            gap = 0;
        else if (roll < 93)
            gap = $urandom_range(3, 1);
        else
            gap = $urandom_range(40, 8);
        if (gap > 0) begin
            start    <= 1'b0;
            i_sample <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic flag_field(input string field, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("Mismatch on %s at result %0d: expected %0d, got %0d",
                     field, results_checked, want, got);
    endtask

    always @(posedge i_clk) begin
        cpc_pkg::t_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_polar.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result word: %h", o_result);
            end else begin
                want = pending_polar.pop_front();
                if (o_result.magnitude_out !== want.magnitude_out)
                    flag_field("magnitude", longint'(want.magnitude_out),
                               longint'(o_result.magnitude_out));
                if (o_result.phase_out !== want.phase_out)
                    flag_field("phase", longint'(want.phase_out),
                               longint'(o_result.phase_out));
                if (o_result.intensity_out !== want.intensity_out)
                    flag_field("intensity", longint'(want.intensity_out),
                               longint'(o_result.intensity_out));
            end
            results_checked++;
        end
    end

    initial begin
        t_row             row;
        cpc_pkg::t_sample w;
        cpc_pkg::t_result want;
        bit               calm;
        int               drain_at;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < DIRECTED_ROWS; k++) begin
            row = DIRECTED[k];
            w.sample_real = row.re;
            w.sample_imag = row.im;
            want = polar_of(w);
            if ((row.known & KNOWN_MAG) != 0)
                want.magnitude_out = row.mag;
            if ((row.known & KNOWN_PH) != 0)
                want.phase_out = row.ph;
            if ((row.known & KNOWN_INT) != 0)
                want.intensity_out = row.inten;
            send_word(w, want);
            rest_after_word(1'b0);
        end

        calm = 1'b1;
        drain_at = $urandom_range(RANDOM_WORDS - 200, 200);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Mix back-to-back stretches with gappy ones, picked at random per 64 words.
            if (n % 64 == 0)
                calm = ($urandom_range(2) == 0);
            w = random_word();
            send_word(w, polar_of(w));
            if (n == drain_at) begin
                start <= 1'b0;
                do @(posedge i_clk); while (pending_polar.size() != 0);
            end else begin
                rest_after_word(calm);
            end
        end
        start <= 1'b0;

        while (pending_polar.size() != 0)
            @(posedge i_clk);
        repeat (cpc_pkg::LATENCY + 8) @(posedge i_clk);

        $display("Sent %0d words (%0d directed), checked %0d results, %0d mismatches.",
                 words_sent, DIRECTED_ROWS, results_checked, mismatch_count);
        $display("Stimulus covered axes, extremes, the pi wrap, gaps and a full drain.");
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
